FILE: hdl/pipt_pkg.sv
`timescale 1ns / 1ps

package pipt_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 16;

   // result request carries one byte, inside flag in bit 0
   localparam int RSP_BITS = 8;

   // which edge the datapath works on
   typedef enum logic {
      EDGE_OPEN  = 1'b0,   // previous vertex to current vertex
      EDGE_CLOSE = 1'b1    // current (last) vertex back to first vertex
   } edge_sel_type;

   typedef struct packed {
      logic         load;      // latch an accepted request
      logic         setup;     // form edge deltas and straddle test
      logic         mul;       // multiply magnitudes, arm divider
      logic         div_step;  // one restoring division step
      logic         apply;     // update parity and vertex history
      logic         finish;    // load result register, clear polygon state
      edge_sel_type edge_sel;
   } cmd_type;

   typedef struct packed {
      logic hit;    // edge straddles the query y and is a real edge
      logic last;   // request held is the final vertex
   } status_type;

endpackage

FILE: hdl/point_in_polygon_test_core.sv
`timescale 1ns / 1ps

// even-odd ray casting point-in-polygon test
// req channel: one request per polygon vertex, in order, each carrying the query
//   point and the vertex; req_tlast marks the final vertex of the polygon
// rsp channel: one request per polygon, sent after the last vertex, bit 0 of
//   rsp_tdata is 1 when the point lies inside
// each edge whose ends straddle the query y goes through one 2*COORD_BITS x
//   COORD_BITS restoring divider at one quotient bit per cycle; that divider
//   sets the rate
// each request steps through load, setup and multiply, then the divider steps
//   when the edge straddles, then apply; the last vertex runs the closing edge
//   too before the result is loaded
// one request is worked on at a time; req_tready is high only while idle
// the result sits in an output register, so a new polygon may start while
//   the previous result still waits; if the receiver stalls, the next result
//   waits until the register is taken
// reset (synchronous, active high) clears parity and polygon progress and
//   drops rsp_tvalid; no clearing pass is needed
module point_in_polygon_test_core #(
   parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: query_x, query_y, vertex_x, vertex_y from bit 0 up, zero padded
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   input  logic                                req_tlast,   // last_vertex
   // response: inside_res in bit 0, zero padded
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pipt_pkg::RSP_BITS-1:0]       rsp_tdata
);
   import pipt_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // sequencer: edge order, divider step count and result handshake
   pipt_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // vertex history, edge deltas, multiplier, divider and parity
   pipt_dpath #(
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: hdl/pipt_dpath.sv
`timescale 1ns / 1ps

module pipt_dpath #(
   parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tlast,
   input  pipt_pkg::cmd_type                      cmd,
   output pipt_pkg::status_type                   sts,
   output logic [pipt_pkg::RSP_BITS-1:0]          rsp_tdata
);
   import pipt_pkg::*;

   localparam int W = COORD_BITS;

   logic signed [W-1:0] qx_ff, qy_ff, vx_ff, vy_ff;
   logic signed [W-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic                last_ff, parity_ff, started_ff, result_ff;
   logic [W-1:0]        mag_dx_ff, mag_dn_ff, mag_dd_ff;
   logic                neg_ff, hit_ff;
   logic [W:0]          acc_ff;
   logic [2*W-1:0]      num_ff;

   logic signed [W-1:0] xi, yi, xj, yj;
   logic signed [W:0]   dx, dn, dd;
   logic [W:0]          dx_neg, dn_neg, dd_neg;
   logic                straddle;
   logic [2*W-1:0]      prod;
   logic [W:0]          rem_sh, rem_sub;
   logic                ge;
   logic signed [W+1:0] q, crossing, qx_ext;
   logic                toggle;

   // edge endpoints: i is the current vertex, j the previous one; on the closing edge i is the first, j the last
   always_comb begin
      if (cmd.edge_sel == EDGE_CLOSE) begin
         xi = first_x_ff;
         yi = first_y_ff;
         xj = vx_ff;
         yj = vy_ff;
      end else begin
         xi = vx_ff;
         yi = vy_ff;
         xj = prev_x_ff;
         yj = prev_y_ff;
      end
   end

   assign dx = {xj[W-1], xj} - {xi[W-1], xi};
   assign dn = {qy_ff[W-1], qy_ff} - {yi[W-1], yi};
   assign dd = {yj[W-1], yj} - {yi[W-1], yi};
   assign dx_neg = ~dx + 1'b1;
   assign dn_neg = ~dn + 1'b1;
   assign dd_neg = ~dd + 1'b1;
   assign straddle = (yi > qy_ff) != (yj > qy_ff);

   assign prod = {{W{1'b0}}, mag_dx_ff} * {{W{1'b0}}, mag_dn_ff};

   // restoring divider step
   assign rem_sh  = {acc_ff[W-1:0], num_ff[2*W-1]};
   assign ge      = rem_sh >= {1'b0, mag_dd_ff};
   assign rem_sub = rem_sh - {1'b0, mag_dd_ff};

   // crossing x and compare
   assign q        = neg_ff ? $signed(-{2'b00, num_ff[W-1:0]})
                            : $signed({2'b00, num_ff[W-1:0]});
   assign crossing = $signed({{2{xi[W-1]}}, xi}) + q;
   assign qx_ext   = $signed({{2{qx_ff[W-1]}}, qx_ff});
   assign toggle   = hit_ff && (qx_ext < crossing);

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff  <= 1'b0;
         started_ff <= 1'b0;
         result_ff  <= 1'b0;
      end else begin
         if (cmd.apply) begin
            if (cmd.edge_sel == EDGE_OPEN) begin
               if (!started_ff) begin
                  first_x_ff <= vx_ff;
                  first_y_ff <= vy_ff;
                  parity_ff  <= 1'b0;
                  started_ff <= 1'b1;
               end else begin
                  parity_ff <= parity_ff ^ toggle;
               end
               prev_x_ff <= vx_ff;
               prev_y_ff <= vy_ff;
            end else begin
               parity_ff <= parity_ff ^ toggle;
            end
         end
         if (cmd.finish) begin
            result_ff  <= parity_ff;
            parity_ff  <= 1'b0;
            started_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qx_ff   <= req_tdata[W-1:0];
         qy_ff   <= req_tdata[2*W-1:W];
         vx_ff   <= req_tdata[3*W-1:2*W];
         vy_ff   <= req_tdata[4*W-1:3*W];
         last_ff <= req_tlast;
      end
      if (cmd.setup) begin
         mag_dx_ff <= dx[W] ? dx_neg[W-1:0] : dx[W-1:0];
         mag_dn_ff <= dn[W] ? dn_neg[W-1:0] : dn[W-1:0];
         mag_dd_ff <= dd[W] ? dd_neg[W-1:0] : dd[W-1:0];
         neg_ff    <= dx[W] ^ dn[W] ^ dd[W];
         hit_ff    <= straddle && ((cmd.edge_sel == EDGE_CLOSE) || started_ff);
      end
      if (cmd.mul) begin
         num_ff <= prod;
         acc_ff <= '0;
      end else if (cmd.div_step) begin
         acc_ff <= ge ? rem_sub : rem_sh;
         num_ff <= {num_ff[2*W-2:0], ge};
      end
   end

   assign sts.hit  = hit_ff;
   assign sts.last = last_ff;
   assign rsp_tdata = {{(RSP_BITS-1){1'b0}}, result_ff};

endmodule

FILE: hdl/pipt_ctrl.sv
`timescale 1ns / 1ps

module pipt_ctrl #(
   parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pipt_pkg::status_type sts,
   output pipt_pkg::cmd_type    cmd
);
   import pipt_pkg::*;

   localparam int DIV_STEPS = 2 * COORD_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_MUL,
      S_DIV,
      S_APPLY,
      S_RESULT
   } state_type;

   state_type    state_ff, state_in;
   edge_sel_type edge_sel_ff, edge_sel_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      edge_sel_in  = edge_sel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.edge_sel = edge_sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load    = 1'b1;
               edge_sel_in = EDGE_OPEN;
               state_in    = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = sts.hit ? S_DIV : S_APPLY;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            if (edge_sel_ff == EDGE_CLOSE) begin
               state_in = S_RESULT;
            end else if (sts.last) begin
               edge_sel_in = EDGE_CLOSE;
               state_in    = S_SETUP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         edge_sel_ff  <= EDGE_OPEN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edge_sel_ff  <= edge_sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: hdl/pipt_check.sv
`timescale 1ns / 1ps

module pipt_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pipt_pkg::RSP_BITS-1:0] rsp_tdata
);
   import pipt_pkg::*;

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // the block is busy in the cycle after taking a vertex
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in work");

   // a response never appears right after a vertex is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response too soon after request");

   // a new response is loaded only while requests are held off
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response loaded while idle");

   // only the inside flag may be set
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_BITS-1:1] == '0))
      else $error("response padding not zero");

endmodule

bind point_in_polygon_test_core pipt_check u_pipt_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
